[design/cmsc_pkg.sv]
// Shared types, constants and helpers for the clock multiplier/shift calculator.
`default_nettype none
package cmsc_pkg;

  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned MULT_W   = 32;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned RES_W    = 24;
  localparam int unsigned DELAY_W  = 8;
  localparam int unsigned TICKS_W  = 30;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned NUM_PAIRS = 3;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd32;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 8'd10;
  localparam logic [TICKS_W-1:0] TICKS_RST     = 30'd1000000;

  typedef enum logic {
    CFG_MAX_DELAY = 1'b0,
    CFG_TICKS     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PAIR_CYC_TO_NS  = 2'd0,
    PAIR_NS_TO_CYC  = 2'd1,
    PAIR_NS_TO_TICK = 2'd2
  } pair_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR_INIT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic pair_init;
    logic div_load;
    logic div_step;
    logic commit;
    logic next_pair;
    logic dec_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic div_last;
    logic fit;
    logic shift_one;
    logic pair_last;
  } sts_t;

  // Resolution in ns for the largest power of ten divisor not above freq.
  function automatic logic [RES_W-1:0] res_lookup(input logic [FREQ_W-1:0] freq);
    logic [RES_W-1:0] r;
    r = '0;
    priority if (freq >= 32'd1000000000) r = 24'd1;
    else if (freq >= 32'd100000000) r = 24'd10;
    else if (freq >= 32'd10000000)  r = 24'd100;
    else if (freq >= 32'd1000000)   r = 24'd1000;
    else if (freq >= 32'd100000)    r = 24'd10000;
    else if (freq >= 32'd10000)     r = 24'd100000;
    else if (freq >= 32'd1000)      r = 24'd1000000;
    else if (freq >= 32'd100)       r = 24'd10000000;
    else                            r = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

[design/clock_mult_shift_calculator.sv]
// A zero frequency goes from pair init straight to the done state; otherwise each pair
//   tries shifts from 32 down, 3 to 96 trials in all, each a divider load, run and check.
// One item at a time, each held in the done state while the last result is still stalled;
//   each trial is a 64-step restoring division on a single shared divider.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, synchronous): idle, no result pending, max delay 10 s, 1 MHz ticks.
`default_nettype none
module clock_mult_shift_calculator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cmsc_pkg::FREQ_W-1:0]   in_clock_freq,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cmsc_pkg::MULT_W-1:0]        out_mult_cyc_to_ns,
  output logic [cmsc_pkg::SHIFT_W-1:0]       out_shift_cyc_to_ns,
  output logic [cmsc_pkg::MULT_W-1:0]        out_mult_ns_to_cyc,
  output logic [cmsc_pkg::SHIFT_W-1:0]       out_shift_ns_to_cyc,
  output logic [cmsc_pkg::MULT_W-1:0]        out_mult_ns_to_ticks,
  output logic [cmsc_pkg::SHIFT_W-1:0]       out_shift_ns_to_ticks,
  output logic [cmsc_pkg::RES_W-1:0]         out_res_nanoseconds,
  output logic                               out_res_whole_second,
  output logic                               out_bad_freq,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [cmsc_pkg::TICKS_W-1:0]  cfg_data
);
  import cmsc_pkg::*;

  logic [DELAY_W-1:0] max_delay_r;
  logic [TICKS_W-1:0] ticks_r;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r <= MAX_DELAY_RST;
      ticks_r     <= TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_DELAY: max_delay_r <= cfg_data[DELAY_W-1:0];
        CFG_TICKS:     ticks_r     <= cfg_data;
        default:       ;
      endcase
    end
  end

  cmsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmsc_dp u_dp (
    .clk                   (clk),
    .max_delay             (max_delay_r),
    .ticks                 (ticks_r),
    .in_clock_freq         (in_clock_freq),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_mult_cyc_to_ns    (out_mult_cyc_to_ns),
    .out_shift_cyc_to_ns   (out_shift_cyc_to_ns),
    .out_mult_ns_to_cyc    (out_mult_ns_to_cyc),
    .out_shift_ns_to_cyc   (out_shift_ns_to_cyc),
    .out_mult_ns_to_ticks  (out_mult_ns_to_ticks),
    .out_shift_ns_to_ticks (out_shift_ns_to_ticks),
    .out_res_nanoseconds   (out_res_nanoseconds),
    .out_res_whole_second  (out_res_whole_second),
    .out_bad_freq          (out_bad_freq)
  );

endmodule
`default_nettype wire

[design/cmsc_ctrl.sv]
// Sequencer for the shift search: one trial division at a time, three pairs.
`default_nettype none
module cmsc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire cmsc_pkg::sts_t sts,
  output cmsc_pkg::cmd_t     cmd
);
  import cmsc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PAIR_INIT;
        end
      end
      ST_PAIR_INIT: begin
        if (sts.freq_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.pair_init = 1'b1;
          state_nxt     = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.fit || sts.shift_one) begin
          cmd.commit = 1'b1;
          if (sts.pair_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.next_pair = 1'b1;
            state_nxt     = ST_PAIR_INIT;
          end
        end else begin
          cmd.dec_shift = 1'b1;
          state_nxt     = ST_DIV_LOAD;
        end
      end
      ST_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[design/cmsc_dp.sv]
// Datapath: headroom, bit-serial 64/32 divider, fit test, result registers.
`default_nettype none
module cmsc_dp (
  input  wire logic                              clk,
  input  wire logic [cmsc_pkg::DELAY_W-1:0]      max_delay,
  input  wire logic [cmsc_pkg::TICKS_W-1:0]      ticks,
  input  wire logic [cmsc_pkg::FREQ_W-1:0]       in_clock_freq,
  input  wire cmsc_pkg::cmd_t                    cmd,
  output cmsc_pkg::sts_t                         sts,
  output logic [cmsc_pkg::MULT_W-1:0]            out_mult_cyc_to_ns,
  output logic [cmsc_pkg::SHIFT_W-1:0]           out_shift_cyc_to_ns,
  output logic [cmsc_pkg::MULT_W-1:0]            out_mult_ns_to_cyc,
  output logic [cmsc_pkg::SHIFT_W-1:0]           out_shift_ns_to_cyc,
  output logic [cmsc_pkg::MULT_W-1:0]            out_mult_ns_to_ticks,
  output logic [cmsc_pkg::SHIFT_W-1:0]           out_shift_ns_to_ticks,
  output logic [cmsc_pkg::RES_W-1:0]             out_res_nanoseconds,
  output logic                                   out_res_whole_second,
  output logic                                   out_bad_freq
);
  import cmsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  function automatic logic [3:0] bit_len8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  logic [FREQ_W-1:0]  freq_r;
  logic [7:0]         hi_cyc_r;
  logic [7:0]         hi_ns_r;
  logic [1:0]         pair_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [SHIFT_W-1:0] acc_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [31:0]        rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MULT_W-1:0]  mult_r  [NUM_PAIRS];
  logic [SHIFT_W-1:0] shres_r [NUM_PAIRS];

  logic [39:0]        prod_cyc;
  logic [37:0]        prod_ns;
  logic [31:0]        num_sel;
  logic [31:0]        den_sel;
  logic [SHIFT_W-1:0] acc_sel;
  logic [DVD_W-1:0]   dvd_init;
  logic [32:0]        rem_sh;
  logic [32:0]        rem_sub;
  logic               ge;
  logic               fit;
  logic [RES_W-1:0]   res_ns;

  assign prod_cyc = 40'(max_delay) * 40'(in_clock_freq);
  assign prod_ns  = 38'(max_delay) * 38'(NS_PER_SEC);

  always_comb begin
    unique case (pair_r)
      PAIR_CYC_TO_NS: begin
        num_sel = NS_PER_SEC;
        den_sel = freq_r;
        acc_sel = SHIFT_MAX - SHIFT_W'(bit_len8(hi_cyc_r));
      end
      PAIR_NS_TO_CYC: begin
        num_sel = freq_r;
        den_sel = NS_PER_SEC;
        acc_sel = SHIFT_MAX - SHIFT_W'(bit_len8(hi_ns_r));
      end
      default: begin
        num_sel = 32'(ticks);
        den_sel = NS_PER_SEC;
        acc_sel = SHIFT_MAX - SHIFT_W'(bit_len8(hi_ns_r));
      end
    endcase
  end

  assign dvd_init = (DVD_W'(num_sel) << shift_r) + DVD_W'(den_sel >> 1);
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, den_sel};
  assign rem_sub  = rem_sh - {1'b0, den_sel};
  assign fit      = (dvd_r >> acc_r) == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq_r   <= in_clock_freq;
      hi_cyc_r <= prod_cyc[39:32];
      hi_ns_r  <= {2'b00, prod_ns[37:32]};
      pair_r   <= PAIR_CYC_TO_NS;
    end
    if (cmd.pair_init) begin
      shift_r <= SHIFT_MAX;
      acc_r   <= acc_sel;
    end
    if (cmd.dec_shift) shift_r <= shift_r - 1'b1;
    if (cmd.next_pair) pair_r <= pair_r + 1'b1;
    if (cmd.div_load) begin
      dvd_r <= dvd_init;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.commit) begin
      mult_r[pair_r]  <= dvd_r[MULT_W-1:0];
      shres_r[pair_r] <= fit ? shift_r : '0;
    end
  end

  assign res_ns = res_lookup(freq_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (freq_r == '0) begin
        out_mult_cyc_to_ns    <= '0;
        out_shift_cyc_to_ns   <= '0;
        out_mult_ns_to_cyc    <= '0;
        out_shift_ns_to_cyc   <= '0;
        out_mult_ns_to_ticks  <= '0;
        out_shift_ns_to_ticks <= '0;
        out_res_nanoseconds   <= '0;
        out_res_whole_second  <= 1'b0;
        out_bad_freq          <= 1'b1;
      end else begin
        out_mult_cyc_to_ns    <= mult_r[PAIR_CYC_TO_NS];
        out_shift_cyc_to_ns   <= shres_r[PAIR_CYC_TO_NS];
        out_mult_ns_to_cyc    <= mult_r[PAIR_NS_TO_CYC];
        out_shift_ns_to_cyc   <= shres_r[PAIR_NS_TO_CYC];
        out_mult_ns_to_ticks  <= mult_r[PAIR_NS_TO_TICK];
        out_shift_ns_to_ticks <= shres_r[PAIR_NS_TO_TICK];
        out_res_nanoseconds   <= res_ns;
        out_res_whole_second  <= res_ns == '0;
        out_bad_freq          <= 1'b0;
      end
    end
  end

  assign sts.freq_zero = freq_r == '0;
  assign sts.div_last  = cnt_r == CNT_LAST;
  assign sts.fit       = fit;
  assign sts.shift_one = shift_r == SHIFT_W'(1);
  assign sts.pair_last = pair_r == PAIR_NS_TO_TICK;

endmodule
`default_nettype wire

[sim/clock_mult_shift_calculator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for clock_mult_shift_calculator: directed and random frequencies.
module clock_mult_shift_calculator_test;
  import cmsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned DRAIN_CYCLES = 6500;
  localparam int unsigned PRINT_CAP    = 40;
  localparam int unsigned PHASE_ITEMS  = 20;

  typedef struct {
    logic [FREQ_W-1:0]  freq;
    logic [MULT_W-1:0]  mult_cyc_to_ns;
    logic [SHIFT_W-1:0] shift_cyc_to_ns;
    logic [MULT_W-1:0]  mult_ns_to_cyc;
    logic [SHIFT_W-1:0] shift_ns_to_cyc;
    logic [MULT_W-1:0]  mult_ns_to_ticks;
    logic [SHIFT_W-1:0] shift_ns_to_ticks;
    logic [RES_W-1:0]   res_nanoseconds;
    logic               res_whole_second;
    logic               bad_freq;
  } clock_pairs_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FREQ_W-1:0]   in_clock_freq = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MULT_W-1:0]   out_mult_cyc_to_ns;
  logic [SHIFT_W-1:0]  out_shift_cyc_to_ns;
  logic [MULT_W-1:0]   out_mult_ns_to_cyc;
  logic [SHIFT_W-1:0]  out_shift_ns_to_cyc;
  logic [MULT_W-1:0]   out_mult_ns_to_ticks;
  logic [SHIFT_W-1:0]  out_shift_ns_to_ticks;
  logic [RES_W-1:0]    out_res_nanoseconds;
  logic                out_res_whole_second;
  logic                out_bad_freq;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = 1'b0;
  logic [TICKS_W-1:0]  cfg_data = '0;

  clock_pairs_t        pending_pairs[$];
  logic [DELAY_W-1:0]  cur_max_delay = MAX_DELAY_RST;
  logic [TICKS_W-1:0]  cur_ticks = TICKS_RST;
  int unsigned         error_count = 0;
  int unsigned         items_sent = 0;
  int unsigned         results_seen = 0;
  int unsigned         settings_used = 1;
  int unsigned         cycle_count = 0;
  int unsigned         out_hold = 0;
  bit                  steady = 1'b0;

  logic [FREQ_W-1:0] corner_freqs [0:15] = '{
    32'd0, 32'd1, 32'd99, 32'd100, 32'd999, 32'd1000, 32'd32768, 32'd999999,
    32'd1000000, 32'd19200000, 32'd99999999, 32'd100000000, 32'd999999999,
    32'd1000000000, 32'h8000_0000, 32'hFFFF_FFFF
  };

  clock_mult_shift_calculator DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_clock_freq         (in_clock_freq),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mult_cyc_to_ns    (out_mult_cyc_to_ns),
    .out_shift_cyc_to_ns   (out_shift_cyc_to_ns),
    .out_mult_ns_to_cyc    (out_mult_ns_to_cyc),
    .out_shift_ns_to_cyc   (out_shift_ns_to_cyc),
    .out_mult_ns_to_ticks  (out_mult_ns_to_ticks),
    .out_shift_ns_to_ticks (out_shift_ns_to_ticks),
    .out_res_nanoseconds   (out_res_nanoseconds),
    .out_res_whole_second  (out_res_whole_second),
    .out_bad_freq          (out_bad_freq),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pairs.size());
      $display("status: fail");
      $finish;
    end
  end

  // quotient may use 32 bits minus the bit length of the product's upper word
  function automatic int quotient_bits(input logic [63:0] prod);
    logic [63:0] upper;
    int n;
    upper = prod >> 32;
    n = 32;
    while (upper != 0) begin
      upper = upper >> 1;
      n = n - 1;
    end
    return n;
  endfunction

  function automatic void search_shift(input logic [63:0] num, input logic [63:0] den,
                                       input int bits, output logic [MULT_W-1:0] mult,
                                       output logic [SHIFT_W-1:0] shift);
    logic [63:0] q;
    int s;
    bit fits;
    q = '0;
    s = 32;
    fits = 1'b0;
    while (s > 0 && !fits) begin
      q = ((num << s) + (den >> 1)) / den;
      if ((q >> bits) == 0) fits = 1'b1;
      else s = s - 1;
    end
    mult = q[MULT_W-1:0];
    shift = s[SHIFT_W-1:0];
  endfunction

  function automatic clock_pairs_t predict_pairs(input logic [FREQ_W-1:0] f);
    clock_pairs_t p;
    logic [63:0] decade;
    logic [63:0] res;
    int bits;
    p = '{default: '0};
    p.freq = f;
    if (f == 0) begin
      p.bad_freq = 1'b1;
    end else begin
      res = '0;
      decade = 64'(NS_PER_SEC);
      while (decade >= 100 && res == 0) begin
        if (64'(f) >= decade) res = 64'(NS_PER_SEC) / decade;
        decade = decade / 10;
      end
      p.res_nanoseconds = res[RES_W-1:0];
      p.res_whole_second = (res == 0);
      bits = quotient_bits(64'(cur_max_delay) * 64'(f));
      search_shift(64'(NS_PER_SEC), 64'(f), bits, p.mult_cyc_to_ns, p.shift_cyc_to_ns);
      // ticks pair shares the ns-to-cycles headroom
      bits = quotient_bits(64'(cur_max_delay) * 64'(NS_PER_SEC));
      search_shift(64'(f), 64'(NS_PER_SEC), bits, p.mult_ns_to_cyc, p.shift_ns_to_cyc);
      search_shift(64'(cur_ticks), 64'(NS_PER_SEC), bits, p.mult_ns_to_ticks,
                   p.shift_ns_to_ticks);
    end
    return p;
  endfunction

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    logic [FREQ_W-1:0] f;
    logic [FREQ_W-1:0] decade;
    int unsigned w;
    case ($urandom_range(0, 5))
      0, 1: f = $urandom;
      2: begin
        w = $urandom_range(1, 32);
        f = $urandom;
        f = (f >> (32 - w)) | (32'h1 << (w - 1));
      end
      3: begin
        decade = 32'd100;
        repeat ($urandom_range(0, 7)) decade = decade * 10;
        f = decade + $urandom_range(0, 2) - 1;
      end
      4: f = $urandom_range(1, 200);
      default: begin
        case ($urandom_range(0, 2))
          0: f = '0;
          1: f = '1;
          default: f = 32'd1;
        endcase
      end
    endcase
    return f;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [FREQ_W-1:0] f);
    if (got !== want)
      flag_error($sformatf("freq %0d %s: got %0d, expected %0d", f, name, got, want));
  endtask

  task automatic check_result();
    clock_pairs_t want;
    results_seen++;
    if (pending_pairs.size() == 0) begin
      flag_error("result with no item outstanding");
    end else begin
      want = pending_pairs.pop_front();
      compare_field("mult_cyc_to_ns", out_mult_cyc_to_ns, want.mult_cyc_to_ns, want.freq);
      compare_field("shift_cyc_to_ns", out_shift_cyc_to_ns, want.shift_cyc_to_ns, want.freq);
      compare_field("mult_ns_to_cyc", out_mult_ns_to_cyc, want.mult_ns_to_cyc, want.freq);
      compare_field("shift_ns_to_cyc", out_shift_ns_to_cyc, want.shift_ns_to_cyc, want.freq);
      compare_field("mult_ns_to_ticks", out_mult_ns_to_ticks, want.mult_ns_to_ticks,
                    want.freq);
      compare_field("shift_ns_to_ticks", out_shift_ns_to_ticks, want.shift_ns_to_ticks,
                    want.freq);
      compare_field("res_nanoseconds", out_res_nanoseconds, want.res_nanoseconds, want.freq);
      compare_field("res_whole_second", out_res_whole_second, want.res_whole_second,
                    want.freq);
      compare_field("bad_freq", out_bad_freq, want.bad_freq, want.freq);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else if (out_valid && !out_stall) begin
      check_result();
      out_hold = draw_wait();
      out_stall <= (out_hold != 0);
    end else if (out_hold != 0) begin
      out_hold = out_hold - 1;
      out_stall <= (out_hold != 0);
    end
  end

  task automatic send_freq(input logic [FREQ_W-1:0] f);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_clock_freq <= f;
    do @(posedge clk); while (in_stall);
    pending_pairs.push_back(predict_pairs(f));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [TICKS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_DELAY) cur_max_delay = data[DELAY_W-1:0];
    else cur_ticks = data;
  endtask

  // upper data bits are noise on the delay write
  task automatic set_registers(input logic [DELAY_W-1:0] delay,
                               input logic [TICKS_W-1:0] ticks);
    wait_drained();
    write_reg(CFG_MAX_DELAY, {22'($urandom), delay});
    write_reg(CFG_TICKS, ticks);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic test_corner_freqs();
    foreach (corner_freqs[i]) send_freq(corner_freqs[i]);
  endtask

  task automatic test_register_extremes();
    set_registers('0, '0);
    send_freq(32'd1);
    send_freq(32'd100);
    send_freq('1);
    send_freq('0);
    set_registers('1, '1);
    send_freq(32'd1);
    send_freq(32'd16777216);
    send_freq(32'd1000000000);
    send_freq('1);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_registers(8'd255, 30'd1000000000);
        1: set_registers(8'd1, 30'd1);
        2: set_registers(DELAY_W'($urandom_range(0, 255)), 30'($urandom));
        3: set_registers(DELAY_W'($urandom_range(0, 255)),
                         TICKS_W'($urandom_range(1, 1000000000)));
        default: set_registers(MAX_DELAY_RST, TICKS_RST);
      endcase
      steady = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_drained();
        send_freq(pick_freq());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_freqs();
    test_register_extremes();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d frequencies under %0d register settings, zero and full scale included",
             items_sent, settings_used);
    $display("checked %0d results with random gaps and stalls on both channels",
             results_seen);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

[clock_mult_shift_calculator.f]
design/cmsc_pkg.sv
design/cmsc_ctrl.sv
design/cmsc_dp.sv
design/clock_mult_shift_calculator.sv
sim/clock_mult_shift_calculator_test.sv
